/* rtl/scp_pkg.sv */
// Shared types, widths and helpers for the sphere contact projection block.
// Used by the root and divider cells and by the top level.
// No dependencies.
package scp_pkg;

    localparam int COORD_W = 32;          // Q16.16 coordinate
    localparam int MAG_W   = 33;          // magnitude of an offset component
    localparam int SUM_W   = 66;          // sum of three squared magnitudes
    localparam int ROOT_W  = 35;          // distance from the root chain
    localparam int TRIAL_W = 70;          // trial value in a root cell
    localparam int DEN_W   = 36;          // divisor, twice the distance
    localparam int NUM_W   = 66;          // dividend of a divider lane
    localparam int QUO_W   = 31;          // quotient bits per divider lane
    localparam int LANES   = 6;           // three normal lanes, three projection lanes
    localparam int RAD_W   = 31;
    localparam int NRM_W   = 16;
    localparam int EPS_W   = 17;
    localparam int DEF_COORD_EPSILON = 1;

    // register map, word index
    typedef enum logic [2:0] {
        REG_CENTRE_X   = 3'd0,
        REG_CENTRE_Y   = 3'd1,
        REG_CENTRE_Z   = 3'd2,
        REG_RADIUS     = 3'd3,
        REG_TOLERANCE  = 3'd4,
        REG_SIDE_SIGNS = 3'd5,
        REG_SOLID_MODE = 3'd6,
        REG_DIMENSIONS = 3'd7
    } cfg_idx_t;

    // travels with a transaction along the root chain
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [2:0]            nz;
    } sq_side_t;

    // travels with a transaction along the divider chain
    typedef struct packed {
        logic [2:0]         neg;
        logic               hit;
        logic [COORD_W-1:0] pen;
        logic               dist_zero;
        logic               dist_small;
    } div_side_t;

    // clamp to the signed 32 bit range
    function automatic logic [COORD_W-1:0] sat32(input logic signed [35:0] v);
        logic [COORD_W-1:0] r;
        if (v > 36'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -36'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/scp_sqrt_cell.sv */
// One digit of the integer square root: tries one root bit, keeps remainder.
// Depends on scp_pkg.
module scp_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [scp_pkg::SUM_W-1:0]           in_rem,
    input  logic [scp_pkg::ROOT_W-1:0]          in_root,
    input  scp_pkg::sq_side_t                   in_side,
    output logic                                out_valid,
    output logic [scp_pkg::SUM_W-1:0]           out_rem,
    output logic [scp_pkg::ROOT_W-1:0]          out_root,
    output scp_pkg::sq_side_t                   out_side
);
    import scp_pkg::*;

    logic [TRIAL_W-1:0] trial;
    logic               take;
    logic               valid_reg;
    logic [SUM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    sq_side_t           side_reg;

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    always_comb
    begin
        trial     = (TRIAL_W'(in_root) << (BIT + 1)) + (TRIAL_W'(1) << (2 * BIT));
        take      = TRIAL_W'(in_rem) >= trial;
        rem_next  = take ? (in_rem - trial[SUM_W-1:0]) : in_rem;
        root_next = take ? (in_root | (ROOT_W'(1) << BIT)) : in_root;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/scp_div_cell.sv */
// One quotient bit of six restoring divisions sharing one divisor.
// Depends on scp_pkg.
module scp_div_cell #(
    parameter int BIT = 0
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            in_valid,
    input  logic [scp_pkg::DEN_W-1:0]                       in_den,
    input  logic [scp_pkg::LANES-1:0][scp_pkg::NUM_W-1:0]   in_rem,
    input  logic [scp_pkg::LANES-1:0][scp_pkg::QUO_W-1:0]   in_quo,
    input  scp_pkg::div_side_t                              in_side,
    output logic                                            out_valid,
    output logic [scp_pkg::DEN_W-1:0]                       out_den,
    output logic [scp_pkg::LANES-1:0][scp_pkg::NUM_W-1:0]   out_rem,
    output logic [scp_pkg::LANES-1:0][scp_pkg::QUO_W-1:0]   out_quo,
    output scp_pkg::div_side_t                              out_side
);
    import scp_pkg::*;

    logic [NUM_W-1:0]                   step;
    logic [LANES-1:0][NUM_W-1:0]        rem_reg, rem_next;
    logic [LANES-1:0][QUO_W-1:0]        quo_reg, quo_next;
    logic                               valid_reg;
    logic [DEN_W-1:0]                   den_reg;
    div_side_t                          side_reg;

    // subtract the shifted divisor where it fits, lane by lane
    always_comb
    begin
        step = NUM_W'(in_den) << BIT;
        for (int l = 0; l < LANES; l++)
        begin
            if (in_rem[l] >= step)
            begin
                rem_next[l] = in_rem[l] - step;
                quo_next[l] = in_quo[l] | (QUO_W'(1) << BIT);
            end
            else
            begin
                rem_next[l] = in_rem[l];
                quo_next[l] = in_quo[l];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= in_den;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

/* rtl/sphere_contact_projection.sv */
// Top level of the sphere contact projection block: register file, front
// stages, root chain, divider chain and result stage.
// Depends on scp_pkg, scp_sqrt_cell and scp_div_cell.
//
// Usage:
//   Configuration goes through the APB-style port (byte address 4*index,
//   pready always high); write it only while no transaction is in flight.
//   A point transaction is accepted at a rising edge with start high and
//   busy low; busy is never raised, so a point may be offered every cycle.
//   Each point gives one result, shown for one cycle with done high. The
//   path is 71 register stages, the first loaded at the accepting edge:
//   offset, squares, sum, 35 root cells, one multiply stage, 31 divider
//   cells and the output register.
//   Throughput is one point per cycle; latency is set by the cell chains,
//   one root bit and one quotient bit per cell.
//   The receiver cannot stall: results are presented once and dropped if
//   not taken.
//   Reset (rst_n low, asynchronous) empties the pipeline and restores the
//   register defaults: centre 0, radius 0, tolerance 0, no side limits,
//   shell mode, three dimensions.
module sphere_contact_projection #(
    parameter int COORD_EPSILON = scp_pkg::DEF_COORD_EPSILON
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // point transactions
    input  logic                                start,
    output logic                                busy,
    input  logic signed [scp_pkg::COORD_W-1:0]  point_x,
    input  logic signed [scp_pkg::COORD_W-1:0]  point_y,
    input  logic signed [scp_pkg::COORD_W-1:0]  point_z,
    // results
    output logic                                done,
    output logic                                inside_res,
    output logic signed [scp_pkg::COORD_W-1:0]  penetration_depth,
    output logic signed [scp_pkg::NRM_W-1:0]    normal_x,
    output logic signed [scp_pkg::NRM_W-1:0]    normal_y,
    output logic signed [scp_pkg::NRM_W-1:0]    normal_z,
    output logic signed [scp_pkg::COORD_W-1:0]  proj_x,
    output logic signed [scp_pkg::COORD_W-1:0]  proj_y,
    output logic signed [scp_pkg::COORD_W-1:0]  proj_z
);
    import scp_pkg::*;

    localparam logic [EPS_W-1:0] EPS = EPS_W'(COORD_EPSILON);

    // ---------------- configuration registers ----------------
    logic [2:0][COORD_W-1:0] centre_reg;
    logic [RAD_W-1:0]        radius_reg;
    logic [RAD_W-1:0]        tol_reg;
    logic [5:0]              sides_reg;
    logic                    solid_reg;
    logic [1:0]              dims_reg;
    logic                    cfg_wr;
    cfg_idx_t                cfg_idx;
    logic                    two_d;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = cfg_idx_t'(paddr[4:2]);
    assign two_d   = (dims_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= '0;
            radius_reg <= '0;
            tol_reg    <= '0;
            sides_reg  <= '0;
            solid_reg  <= 1'b0;
            dims_reg   <= 2'd3;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_CENTRE_X:   centre_reg[0] <= pwdata;
                REG_CENTRE_Y:   centre_reg[1] <= pwdata;
                REG_CENTRE_Z:   centre_reg[2] <= pwdata;
                REG_RADIUS:     radius_reg    <= pwdata[RAD_W-1:0];
                REG_TOLERANCE:  tol_reg       <= pwdata[RAD_W-1:0];
                REG_SIDE_SIGNS: sides_reg     <= pwdata[5:0];
                REG_SOLID_MODE: solid_reg     <= pwdata[0];
                REG_DIMENSIONS: dims_reg      <= pwdata[1:0];
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (cfg_idx)
            REG_CENTRE_X:   prdata = centre_reg[0];
            REG_CENTRE_Y:   prdata = centre_reg[1];
            REG_CENTRE_Z:   prdata = centre_reg[2];
            REG_RADIUS:     prdata = {1'b0, radius_reg};
            REG_TOLERANCE:  prdata = {1'b0, tol_reg};
            REG_SIDE_SIGNS: prdata = {26'd0, sides_reg};
            REG_SOLID_MODE: prdata = {31'd0, solid_reg};
            REG_DIMENSIONS: prdata = {30'd0, dims_reg};
        endcase
    end

    // ---------------- stage A: offset and magnitude ----------------
    logic                   acc;
    logic signed [MAG_W:0]  d_a [3];
    logic                   a_valid_reg;
    sq_side_t               a_side_reg, a_side_next;

    assign busy = 1'b0;
    assign acc  = start && !busy;

    always_comb
    begin
        d_a[0] = 34'(point_x) - 34'(signed'(centre_reg[0]));
        d_a[1] = 34'(point_y) - 34'(signed'(centre_reg[1]));
        d_a[2] = two_d ? 34'sd0 : (34'(point_z) - 34'(signed'(centre_reg[2])));
        for (int i = 0; i < 3; i++)
        begin
            a_side_next.neg[i] = d_a[i][MAG_W];
            a_side_next.nz[i]  = (d_a[i] != 34'sd0);
            a_side_next.mag[i] = d_a[i][MAG_W] ? MAG_W'(-d_a[i]) : MAG_W'(d_a[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= acc;
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= a_side_next;
    end

    // ---------------- stage B: squares ----------------
    logic                         b_valid_reg;
    logic [2:0][2*MAG_W-1:0]      sq_reg;
    sq_side_t                     b_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            sq_reg[i] <= (2*MAG_W)'(a_side_reg.mag[i]) * (2*MAG_W)'(a_side_reg.mag[i]);
        b_side_reg <= a_side_reg;
    end

    // ---------------- stage C: sum of squares ----------------
    logic             c_valid_reg;
    logic [SUM_W-1:0] sum_reg;
    sq_side_t         c_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        c_side_reg <= b_side_reg;
    end

    // ---------------- root chain ----------------
    logic                  s_valid [ROOT_W+1];
    logic [SUM_W-1:0]      s_rem   [ROOT_W+1];
    logic [ROOT_W-1:0]     s_root  [ROOT_W+1];
    sq_side_t              s_side  [ROOT_W+1];

    assign s_valid[0] = c_valid_reg;
    assign s_rem[0]   = sum_reg;
    assign s_root[0]  = '0;
    assign s_side[0]  = c_side_reg;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_sqrt
        scp_sqrt_cell #(.BIT(ROOT_W - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s_valid[k]),
            .in_rem    (s_rem[k]),
            .in_root   (s_root[k]),
            .in_side   (s_side[k]),
            .out_valid (s_valid[k+1]),
            .out_rem   (s_rem[k+1]),
            .out_root  (s_root[k+1]),
            .out_side  (s_side[k+1])
        );
    end

    // ---------------- stage M: hit test, dividends ----------------
    logic [ROOT_W-1:0]             root_dist;
    sq_side_t                      ms;
    logic [35:0]                   lim;
    logic signed [36:0]            lo_lim;
    logic                          hit_m;
    logic [1:0]                    sgn;
    logic [LANES-1:0][NUM_W-1:0]   num_next;
    logic                          m_valid_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [LANES-1:0][NUM_W-1:0]   num_reg;
    div_side_t                     m_side_reg, m_side_next;

    assign root_dist = s_root[ROOT_W];
    assign ms        = s_side[ROOT_W];

    always_comb
    begin
        lim    = 36'(radius_reg) + 36'(tol_reg) + 36'(EPS);
        lo_lim = 37'(radius_reg) - 37'(tol_reg) - 37'(EPS);
        hit_m  = (36'(root_dist) <= lim);
        if (!solid_reg && (signed'({2'b00, root_dist}) < lo_lim))
            hit_m = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sgn = sides_reg[2*i +: 2];
            if (!(two_d && i == 2))
            begin
                if (sgn[0] && ms.neg[i])
                    hit_m = 1'b0;
                if (sgn[1] && ms.nz[i] && !ms.neg[i])
                    hit_m = 1'b0;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            num_next[i]     = (NUM_W'(ms.mag[i]) << 15) + NUM_W'(root_dist);
            num_next[i + 3] = ((NUM_W'(radius_reg) * NUM_W'(ms.mag[i])) << 1)
                              + NUM_W'(root_dist);
        end
        m_side_next.neg        = ms.neg;
        m_side_next.hit        = hit_m;
        m_side_next.pen        = sat32(36'(root_dist) - 36'(radius_reg));
        m_side_next.dist_zero  = (root_dist == '0);
        m_side_next.dist_small = (root_dist == '0) || (36'(root_dist) < 36'(EPS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= s_valid[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= {root_dist, 1'b0};
        num_reg    <= num_next;
        m_side_reg <= m_side_next;
    end

    // ---------------- divider chain ----------------
    logic                            v_valid [QUO_W+1];
    logic [DEN_W-1:0]                v_den   [QUO_W+1];
    logic [LANES-1:0][NUM_W-1:0]     v_rem   [QUO_W+1];
    logic [LANES-1:0][QUO_W-1:0]     v_quo   [QUO_W+1];
    div_side_t                       v_side  [QUO_W+1];

    assign v_valid[0] = m_valid_reg;
    assign v_den[0]   = den_reg;
    assign v_rem[0]   = num_reg;
    assign v_quo[0]   = '0;
    assign v_side[0]  = m_side_reg;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_div
        scp_div_cell #(.BIT(QUO_W - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v_valid[k]),
            .in_den    (v_den[k]),
            .in_rem    (v_rem[k]),
            .in_quo    (v_quo[k]),
            .in_side   (v_side[k]),
            .out_valid (v_valid[k+1]),
            .out_den   (v_den[k+1]),
            .out_rem   (v_rem[k+1]),
            .out_quo   (v_quo[k+1]),
            .out_side  (v_side[k+1])
        );
    end

    // ---------------- result stage ----------------
    div_side_t                   fs;
    logic [LANES-1:0][QUO_W-1:0] fq;
    logic [2:0][NRM_W-1:0]       nrm_next;
    logic [2:0][COORD_W-1:0]     prj_next;
    logic signed [35:0]          off;
    logic [NRM_W-1:0]            q16;
    logic                        done_reg;
    logic                        hit_reg;
    logic [COORD_W-1:0]          pen_reg;
    logic [2:0][NRM_W-1:0]       nrm_reg;
    logic [2:0][COORD_W-1:0]     prj_reg;

    assign fs = v_side[QUO_W];
    assign fq = v_quo[QUO_W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q16 = fq[i][NRM_W-1:0];
            off = fs.neg[i] ? -36'(fq[i + 3]) : 36'(fq[i + 3]);
            if ((two_d && i == 2) || fs.dist_zero)
                nrm_next[i] = '0;
            else
                nrm_next[i] = fs.neg[i] ? -q16 : q16;
            if (two_d && i == 2)
                prj_next[i] = '0;
            else if (fs.dist_small)
                prj_next[i] = centre_reg[i];
            else
                prj_next[i] = sat32(36'(signed'(centre_reg[i])) + off);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v_valid[QUO_W];
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= fs.hit;
        pen_reg <= fs.pen;
        nrm_reg <= nrm_next;
        prj_reg <= prj_next;
    end

    assign done              = done_reg;
    assign inside_res        = hit_reg;
    assign penetration_depth = pen_reg;
    assign normal_x          = nrm_reg[0];
    assign normal_y          = nrm_reg[1];
    assign normal_z          = nrm_reg[2];
    assign proj_x            = prj_reg[0];
    assign proj_y            = prj_reg[1];
    assign proj_z            = prj_reg[2];

    // ---------------- checks ----------------
    a_nrm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
                  normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
                  normal_z <= 16'sd16384 && normal_z >= -16'sd16384))
        else $error("normal outside unit range");

    a_circle_z: assert property (@(posedge clk) disable iff (!rst_n)
        (done && two_d) |-> (normal_z == '0 && proj_z == '0))
        else $error("z result non-zero in circle mode");

    a_solid_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && inside_res && solid_reg) |->
            (36'(signed'(penetration_depth)) <= signed'(36'(tol_reg) + 36'(EPS))))
        else $error("solid hit beyond tolerance band");

endmodule

/* tb/tb.sv */
// Self-checking testbench for sphere_contact_projection: APB setup, point
// transactions in random bursts, and a scoreboard that predicts each result.
// Depends on scp_pkg and the sphere_contact_projection RTL.
module tb;
    import scp_pkg::*;

    typedef struct {
        bit          hit_flag;
        logic [31:0] pen;
        logic [15:0] nx, ny, nz;
        logic [31:0] px, py, pz;
    } contact_t;

    // expected contacts, predicted from the current geometry
    class contact_board;
        longint cen[3];
        longint rad, tol;
        int     sides, dims;
        bit     solid;
        contact_t pending[$];
        int     errors;

        function new();
            cen = '{0, 0, 0};
            rad = 0; tol = 0; sides = 0; solid = 0; dims = 3; errors = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [31:0] v);
            case (idx)
                REG_CENTRE_X:   cen[0] = longint'(signed'(v));
                REG_CENTRE_Y:   cen[1] = longint'(signed'(v));
                REG_CENTRE_Z:   cen[2] = longint'(signed'(v));
                REG_RADIUS:     rad = longint'(v[30:0]);
                REG_TOLERANCE:  tol = longint'(v[30:0]);
                REG_SIDE_SIGNS: sides = int'(v[5:0]);
                REG_SOLID_MODE: solid = v[0];
                REG_DIMENSIONS: dims = int'(v[1:0]);
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // accepted point: work out its contact
        function void note(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            longint      pt[3], off[3], nrm[3], prj[3];
            logic [32:0] mag[3];
            logic [65:0] sum;
            logic [34:0] root_dist, trial;
            logic [69:0] tsq;
            logic [71:0] num;
            longint      q, hi_lim, lo_lim;
            int          axes;
            bit          hit;
            contact_t    c;
            pt[0] = longint'(signed'(x));
            pt[1] = longint'(signed'(y));
            pt[2] = longint'(signed'(z));
            axes = (dims == 2) ? 2 : 3;
            sum = '0;
            for (int i = 0; i < 3; i++)
            begin
                off[i] = (i < axes) ? pt[i] - cen[i] : 0;
                mag[i] = (off[i] < 0) ? 33'(-off[i]) : 33'(off[i]);
                sum += 66'(mag[i]) * 66'(mag[i]);
                nrm[i] = 0;
                prj[i] = 0;
            end
            // bitwise floor square root
            root_dist = '0;
            for (int b = 34; b >= 0; b--)
            begin
                trial = root_dist | (35'd1 << b);
                tsq = 70'(trial) * 70'(trial);
                if (tsq <= 70'(sum))
                    root_dist = trial;
            end
            hi_lim = rad + tol + DEF_COORD_EPSILON;
            lo_lim = rad - tol - DEF_COORD_EPSILON;
            hit = longint'(root_dist) <= hi_lim;
            if (!solid && longint'(root_dist) < lo_lim)
                hit = 0;
            for (int i = 0; i < axes; i++)
            begin
                if (((sides >> (2 * i)) & 1) && off[i] < 0) hit = 0;
                if (((sides >> (2 * i)) & 2) && off[i] > 0) hit = 0;
            end
            for (int i = 0; i < axes; i++)
            begin
                if (root_dist != 0)
                begin
                    q = ((longint'(mag[i]) << 15) + longint'(root_dist))
                        / (2 * longint'(root_dist));
                    nrm[i] = (off[i] < 0) ? -q : q;
                end
                if (root_dist == 0 || longint'(root_dist) < DEF_COORD_EPSILON)
                    prj[i] = cen[i];
                else
                begin
                    num = 72'(rad) * 72'(mag[i]) * 72'd2 + 72'(root_dist);
                    q = longint'(num / (72'(root_dist) * 72'd2));
                    prj[i] = clamp32(cen[i] + ((off[i] < 0) ? -q : q));
                end
            end
            c.hit_flag = hit;
            c.pen = 32'(clamp32(longint'(root_dist) - rad));
            c.nx = 16'(nrm[0]); c.ny = 16'(nrm[1]); c.nz = 16'(nrm[2]);
            c.px = 32'(prj[0]); c.py = 32'(prj[1]); c.pz = 32'(prj[2]);
            pending.push_back(c);
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a)
            begin
                $error("%s: expected %h, got %h", name, e, a);
                errors++;
            end
        endfunction

        function void check(contact_t a);
            contact_t e;
            if (pending.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp("inside_res", 32'(e.hit_flag), 32'(a.hit_flag));
            cmp("penetration_depth", e.pen, a.pen);
            cmp("normal_x", 32'(e.nx), 32'(a.nx));
            cmp("normal_y", 32'(e.ny), 32'(a.ny));
            cmp("normal_z", 32'(e.nz), 32'(a.nz));
            cmp("proj_x", e.px, a.px);
            cmp("proj_y", e.py, a.py);
            cmp("proj_z", e.pz, a.pz);
        endfunction
    endclass

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready, start, busy, done, inside_res;
    logic signed [31:0] point_x, point_y, point_z, penetration_depth;
    logic signed [31:0] proj_x, proj_y, proj_z;
    logic signed [15:0] normal_x, normal_y, normal_z;

    contact_board board = new();
    int burst_left;

    sphere_contact_projection dut (.*);

    initial clk = 0;
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // monitor: note accepted points, check strobed results
    always @(posedge clk)
    begin
        contact_t a;
        if (rst_n)
        begin
            if (start && !busy)
                board.note(point_x, point_y, point_z);
            if (done)
            begin
                a.hit_flag = inside_res; a.pen = penetration_depth;
                a.nx = normal_x; a.ny = normal_y; a.nz = normal_z;
                a.px = proj_x; a.py = proj_y; a.pz = proj_z;
                board.check(a);
            end
        end
    end

    // APB write: setup then access
    task automatic reg_write(cfg_idx_t idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(idx) << 2; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        do @(posedge clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.set_reg(idx, v);
    endtask

    // drain the pipeline before touching registers
    task automatic settle();
        start <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one point transaction, bursts with random gaps
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        start <= 1; point_x <= x; point_y <= y; point_z <= z;
        do @(posedge clk); while (busy);
        if (burst_left == 0)
        begin
            start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        else
            burst_left--;
    endtask

    task automatic set_geometry(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [31:0] r, logic [31:0] t, logic [31:0] s,
                                logic [31:0] m, logic [31:0] dm);
        reg_write(REG_CENTRE_X, cx);
        reg_write(REG_CENTRE_Y, cy);
        reg_write(REG_CENTRE_Z, cz);
        reg_write(REG_RADIUS, r);
        reg_write(REG_TOLERANCE, t);
        reg_write(REG_SIDE_SIGNS, s);
        reg_write(REG_SOLID_MODE, m);
        reg_write(REG_DIMENSIONS, dm);
    endtask

    function automatic logic [31:0] near_offset(logic [31:0] c, logic [31:0] r);
        int span;
        span = (r[30:0] > 31'd100000000) ? 100000000 : int'(r[30:0]) * 2 + 4;
        return c + 32'($urandom_range(0, 2 * span)) - 32'(span);
    endfunction

    initial
    begin
        logic [31:0] cx, cy, cz, r;
        rst_n = 0; start = 0; psel = 0; penable = 0; pwrite = 0;
        paddr = '0; pwdata = '0; point_x = 0; point_y = 0; point_z = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset geometry, zero offset and extremes
        send_point(0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(1, 0, 0);
        send_point(0, 32'hFFFF_FFFF, 0);
        settle();
        // saturating centre and radius, solid, both side bits on x
        set_geometry(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'b00_00_11, 1, 3);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h7FFF_0000, 0);
        send_point(32'h0, 32'h8000_0001, 32'h7FFF_FFFE);
        settle();
        // circle, shell, one-sided limits
        set_geometry(32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678,
                     32'h0002_0000, 32'h0000_1000, 6'b10_01_10, 0, 2);
        send_point(32'h0003_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
        send_point(32'hFFFF_0000, 32'hFFFF_0000, 0);
        send_point(32'h0001_0000, 32'h0001_0000, 0);
        send_point(32'h0001_0000, 32'hFFFF_0000, 5);
        send_point(32'h0001_0001, 32'hFFFF_0000, 0);
        settle();
        // odd dimension codes act as a sphere
        set_geometry(0, 0, 0, 32'h0001_0000, 0, 6'b01_00_00, 0, 0);
        send_point(0, 0, 32'h0001_0000);
        send_point(0, 0, 32'hFFFF_0000);
        settle();
        reg_write(REG_DIMENSIONS, 1);
        send_point(32'h0000_B505, 32'h0000_B505, 0);
        send_point(0, 0, 1);

        // random phases
        for (int ph = 0; ph < 10; ph++)
        begin
            settle();
            cx = $urandom(); cy = $urandom(); cz = $urandom();
            if ($urandom_range(0, 2) != 0)
            begin
                cx = 32'(signed'(cx) >>> 8); cy = 32'(signed'(cy) >>> 8);
                cz = 32'(signed'(cz) >>> 8);
            end
            r = (ph == 3) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0100_0000);
            set_geometry(cx, cy, cz, r,
                         (ph == 5) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h0001_0000),
                         $urandom_range(0, 63), $urandom_range(0, 1),
                         $urandom_range(0, 3));
            for (int n = 0; n < 190; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_point($urandom(), $urandom(), $urandom());
                else
                    send_point(near_offset(cx, r), near_offset(cy, r), near_offset(cz, r));
            end
        end

        settle();
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // hard stop
    initial
    begin
        #4000000;
        $display("tb: FAIL");
        $finish;
    end
endmodule

/* sphere_contact_projection.f */
rtl/scp_pkg.sv
rtl/scp_sqrt_cell.sv
rtl/scp_div_cell.sv
rtl/sphere_contact_projection.sv
tb/tb.sv
